@@ rtl/core/ulb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ulb_pkg;

    localparam int LED_NUM_DEF     = 8;
    localparam int LINE_DEPTH_DEF  = 32;
    localparam int PATTERN_LEN     = 16;
    localparam int MSG_LEN         = 26;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CHAR_LB    = 8'h62;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_5     = 8'h35;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_E     = 8'h45;

    localparam logic [15:0] PATTERN_RESET = 16'hFF00;
    localparam logic [15:0] PERIOD_RESET  = 16'd125;
    localparam logic [15:0] MIN_PERIOD_RESET = 16'd80;

    typedef enum logic [1:0] {
        JOB_TICK,
        JOB_LINE,
        JOB_LONG
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_LONG,
        ST_CMD,
        ST_ZSET,
        ST_ZREP,
        ST_BSKIP,
        ST_BDIG,
        ST_BCONV,
        ST_BREP,
        ST_CLEAR
    } back_state_t;

    function automatic logic [15:0] code_mask(input logic [2:0] k);
        logic [15:0] m;
        begin
            unique case (k)
                3'd0: m = 16'h0000;
                3'd1: m = 16'hFFFF;
                3'd2: m = 16'hFF00;
                3'd3: m = 16'hF0F0;
                3'd4: m = 16'hCCCC;
                3'd5: m = 16'hAAAA;
                default: m = 16'h0000;
            endcase
            return m;
        end
    endfunction

    function automatic logic [7:0] pattern_code(input logic [15:0] p);
        logic [7:0] c;
        begin
            priority if (p == 16'h0000) c = 8'h30;
            else if (p == 16'hFFFF) c = 8'h31;
            else if (p == 16'hFF00) c = 8'h32;
            else if (p == 16'hF0F0) c = 8'h33;
            else if (p == 16'hCCCC) c = 8'h34;
            else if (p == 16'hAAAA) c = 8'h35;
            else c = CHAR_E;
            return c;
        end
    endfunction

    function automatic logic [7:0] long_msg(input logic [4:0] i);
        logic [7:0] c;
        begin
            unique case (i)
                5'd0: c = "C";  5'd1: c = "o";  5'd2: c = "m";  5'd3: c = "m";
                5'd4: c = "a";  5'd5: c = "n";  5'd6: c = "d";  5'd7: c = " ";
                5'd8: c = "t";  5'd9: c = "o";  5'd10: c = "o"; 5'd11: c = " ";
                5'd12: c = "l"; 5'd13: c = "o"; 5'd14: c = "n"; 5'd15: c = "g";
                5'd16: c = ","; 5'd17: c = " "; 5'd18: c = "i"; 5'd19: c = "g";
                5'd20: c = "n"; 5'd21: c = "o"; 5'd22: c = "r"; 5'd23: c = "i";
                5'd24: c = "n"; 5'd25: c = "g";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/uart_led_blink_command_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake               | Content
// s_axis    | s_tvalid / s_tready     | tuser = operation, tdata = rx_byte
// m_axis    | m_tvalid / m_tready     | tdata = led_update..tx_byte, tlast = last
// config    | cfg_valid / cfg_ready   | cfg_data = min_period_ms
// A tick passes through the back end and waits while the result register is held.
// A line end walks the line buffer byte by byte through its read port, and then
// emits one reply beat per cycle while the result register is not held.
// A two-entry job queue lets input beats be taken while the back end runs a tick;
// input waits from a queued line or overflow job until that line is cleared.
// Reset is synchronous; the line buffer holds stale bytes, masked by the length.
module uart_led_blink_command_controller_core #(
    parameter int LED_NUM    = ulb_pkg::LED_NUM_DEF,
    parameter int LINE_DEPTH = ulb_pkg::LINE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // led_update, led_levels, tx_valid, tx_byte, pad
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // min_period_ms
);
    localparam int LW = $clog2(LINE_DEPTH + 1);

    logic [15:0] minp_reg;
    logic        line_free, clear_line, job_valid, job_take;
    ulb_pkg::job_t job;
    logic [$clog2(LINE_DEPTH)-1:0] rd_addr;
    logic [7:0]  rd_data;
    logic [LW-1:0] line_len;
    logic        o_led, o_tx;
    logic [7:0]  o_lv, o_byte;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) minp_reg <= ulb_pkg::MIN_PERIOD_RESET;
        else if (cfg_valid) minp_reg <= cfg_data;
    end

    ulb_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser), .in_byte(s_tdata),
        .line_free, .rd_addr, .rd_data, .line_len, .clear_line,
        .job_valid, .job, .job_take
    );

    ulb_back #(.LED_NUM(LED_NUM), .LINE_DEPTH(LINE_DEPTH)) u_back (
        .aclk, .aresetn, .min_period(minp_reg),
        .job_valid, .job, .job_take, .line_free, .rd_addr, .rd_data, .line_len,
        .clear_line,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_led(o_led), .out_levels(o_lv),
        .out_tx(o_tx), .out_byte(o_byte), .out_last(m_tlast)
    );

    assign m_tdata = {6'b0, o_byte, o_tx, o_lv, o_led};
endmodule
`default_nettype wire

@@ rtl/core/ulb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Accepts input beats, stores line bytes and queues jobs for the back end.
module ulb_front #(
    parameter int LINE_DEPTH = ulb_pkg::LINE_DEPTH_DEF,
    parameter int LW = $clog2(LINE_DEPTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_op,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          line_free,
    input  wire logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
    output logic [7:0]                         rd_data,
    output logic [LW-1:0]                      line_len,
    input  wire logic                          clear_line,
    output logic                               job_valid,
    output ulb_pkg::job_t                      job,
    input  wire logic                          job_take
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int QD = 2;

    logic [7:0]    mem [LINE_DEPTH];
    logic [LW-1:0] len_reg, len_next;
    ulb_pkg::job_t q_reg [QD];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rp_reg, wp_reg;
    logic          busy_reg;
    logic          acc, push;
    ulb_pkg::job_t new_job;

    // Every byte needs queue room, also one that only fills the line and queues no job.
    // Once a line or overflow job is queued, input waits until the line is cleared,
    // so that the line stays still while the back end reads it.
    assign in_ready = (cnt_reg != 2'(QD)) && line_free && !busy_reg;
    assign acc      = in_valid && in_ready;

    always_comb begin
        new_job.kind = ulb_pkg::JOB_TICK;
        push = 1'b0;
        len_next = len_reg;
        if (acc) begin
            if (in_op) begin
                push = 1'b1;
            end else if (len_reg == LW'(LINE_DEPTH)) begin
                new_job.kind = ulb_pkg::JOB_LONG;
                push = 1'b1;
            end else if (in_byte == ulb_pkg::CHAR_CR) begin
                new_job.kind = ulb_pkg::JOB_LINE;
                push = 1'b1;
            end else begin
                len_next = len_reg + 1'b1;
            end
        end
        if (clear_line) len_next = '0;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, job_take};
    end

    always_ff @(posedge aclk) begin
        if (acc && !in_op && len_reg != LW'(LINE_DEPTH) && in_byte != ulb_pkg::CHAR_CR)
            mem[len_reg[AW-1:0]] <= in_byte;
        rd_data <= mem[rd_addr];
        if (push) q_reg[wp_reg] <= new_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            cnt_reg  <= '0;
            rp_reg   <= 1'b0;
            wp_reg   <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (job_take) rp_reg <= ~rp_reg;
            if (clear_line) busy_reg <= 1'b0;
            else if (push && new_job.kind != ulb_pkg::JOB_TICK) busy_reg <= 1'b1;
        end
    end

    assign line_len  = len_reg;
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rp_reg];
endmodule
`default_nettype wire

@@ rtl/core/ulb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Runs queued jobs: LED steps, overflow message and line commands.
module ulb_back #(
    parameter int LED_NUM    = ulb_pkg::LED_NUM_DEF,
    parameter int LINE_DEPTH = ulb_pkg::LINE_DEPTH_DEF,
    parameter int LW = $clog2(LINE_DEPTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [15:0]                   min_period,
    input  wire logic                          job_valid,
    input  wire ulb_pkg::job_t                 job,
    output logic                               job_take,
    output logic                               line_free,
    output logic [$clog2(LINE_DEPTH)-1:0]      rd_addr,
    input  wire logic [7:0]                    rd_data,
    input  wire logic [LW-1:0]                 line_len,
    output logic                               clear_line,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_led,
    output logic [7:0]                         out_levels,
    output logic                               out_tx,
    output logic [7:0]                         out_byte,
    output logic                               out_last
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LI = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;

    ulb_pkg::back_state_t st_reg, st_next;
    logic [15:0] pat_reg [LED_NUM];
    logic [15:0] period_reg, tick_reg;
    logic [3:0]  bit_reg;
    logic [LW:0] pos_reg, pos_next;     // line position
    logic        rd_ok_reg;             // read data belongs to pos_reg
    logic [16:0] val_reg;
    logic [7:0]  dig_reg [5];
    logic [2:0]  nd_reg;
    logic [4:0]  step_reg;

    logic [7:0] cur_char;
    logic       free_out;
    logic       emit, emit_last;
    logic [7:0] emit_byte;
    logic [15:0] tick_inc;
    logic [7:0]  lv;
    logic        tick_fire, out_set, conv_done;
    logic [31:0] div_prod;
    logic [12:0] div_q;
    logic [3:0]  div_r;

    assign free_out = !out_valid || out_ready;
    assign cur_char = (pos_reg < (LW+1)'(line_len) && pos_reg < (LW+1)'(LINE_DEPTH))
                      ? rd_data : 8'h00;
    assign rd_addr  = pos_next[AW-1:0];
    assign tick_inc = tick_reg + 16'd1;
    assign tick_fire = st_reg == ulb_pkg::ST_TICK && !(tick_inc < period_reg) && free_out;
    assign out_set   = tick_fire || (emit && free_out);

    // Decimal digits by reciprocal multiplication; exact for values below 81920.
    assign div_prod  = val_reg[15:0] * 16'hCCCD;
    assign div_q     = div_prod[31:19];
    assign div_r     = 4'(val_reg[15:0] - 16'({div_q, 3'b000}) - 16'({div_q, 1'b0}));
    // A value of zero still gives one digit.
    assign conv_done = (val_reg == 17'd0 && nd_reg != 3'd0) || nd_reg == 3'd5;

    always_comb begin
        lv = '0;
        for (int i = 0; i < LED_NUM && i < 8; i++) lv[i] = pat_reg[i][bit_reg];
    end

    // Reply character for the current step.
    always_comb begin
        emit = 1'b0;
        emit_last = 1'b0;
        emit_byte = 8'h00;
        unique case (st_reg)
            ulb_pkg::ST_LONG: begin
                emit = 1'b1;
                emit_byte = ulb_pkg::long_msg(step_reg);
                emit_last = step_reg == 5'(ulb_pkg::MSG_LEN - 1);
            end
            ulb_pkg::ST_ZREP: begin
                emit = 1'b1;
                if (step_reg == 5'd0) emit_byte = ulb_pkg::CHAR_LZ;
                else if (step_reg == 5'd1) emit_byte = ulb_pkg::CHAR_SPACE;
                else if (step_reg < 5'(LED_NUM + 2))
                    emit_byte = ulb_pkg::pattern_code(pat_reg[LI'(step_reg - 5'd2)]);
                else if (step_reg == 5'(LED_NUM + 2)) emit_byte = ulb_pkg::CHAR_CR;
                else begin
                    emit_byte = ulb_pkg::CHAR_LF;
                    emit_last = 1'b1;
                end
            end
            ulb_pkg::ST_BREP: begin
                emit = 1'b1;
                if (step_reg == 5'd0) emit_byte = ulb_pkg::CHAR_LB;
                else if (step_reg == 5'd1) emit_byte = ulb_pkg::CHAR_SPACE;
                else if (step_reg == 5'd2) emit_byte = dig_reg[nd_reg - 3'd1];
                else if (step_reg == 5'd3) emit_byte = ulb_pkg::CHAR_CR;
                else begin
                    emit_byte = ulb_pkg::CHAR_LF;
                    emit_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        st_next = st_reg;
        pos_next = pos_reg;
        unique case (st_reg)
            ulb_pkg::ST_IDLE: begin
                pos_next = '0;
                if (job_valid) begin
                    unique case (job.kind)
                        ulb_pkg::JOB_TICK: st_next = ulb_pkg::ST_TICK;
                        ulb_pkg::JOB_LONG: st_next = ulb_pkg::ST_LONG;
                        default:           st_next = ulb_pkg::ST_CMD;
                    endcase
                end
            end
            ulb_pkg::ST_TICK:
                if (tick_inc < period_reg) st_next = ulb_pkg::ST_IDLE;
                else if (free_out) st_next = ulb_pkg::ST_IDLE;
            ulb_pkg::ST_LONG:
                if (free_out && emit_last) st_next = ulb_pkg::ST_CLEAR;
            ulb_pkg::ST_CMD: begin
                if (!rd_ok_reg) begin
                    pos_next = pos_reg;
                end else if (cur_char == ulb_pkg::CHAR_Z) begin
                    st_next = ulb_pkg::ST_ZSET;
                    pos_next = (LW+1)'(2);
                end else if (cur_char == ulb_pkg::CHAR_S) begin
                    st_next = ulb_pkg::ST_ZREP;
                end else if (cur_char == ulb_pkg::CHAR_B) begin
                    st_next = ulb_pkg::ST_BSKIP;
                    pos_next = (LW+1)'(2);
                end else begin
                    st_next = ulb_pkg::ST_CLEAR;
                end
            end
            ulb_pkg::ST_ZSET:
                if (rd_ok_reg) begin
                    if (pos_reg == (LW+1)'(LED_NUM + 1)) st_next = ulb_pkg::ST_ZREP;
                    else pos_next = pos_reg + 1'b1;
                end
            ulb_pkg::ST_ZREP:
                if (free_out && emit_last) st_next = ulb_pkg::ST_CLEAR;
            ulb_pkg::ST_BSKIP:
                if (rd_ok_reg) begin
                    if (pos_reg >= (LW+1)'(LINE_DEPTH)) st_next = ulb_pkg::ST_BDIG;
                    else if (cur_char == ulb_pkg::CHAR_SPACE ||
                             (cur_char >= 8'h09 && cur_char <= ulb_pkg::CHAR_CR))
                        pos_next = pos_reg + 1'b1;
                    else st_next = ulb_pkg::ST_BDIG;
                end
            ulb_pkg::ST_BDIG:
                if (rd_ok_reg) begin
                    if (pos_reg < (LW+1)'(LINE_DEPTH) && cur_char >= ulb_pkg::CHAR_0
                        && cur_char <= ulb_pkg::CHAR_9)
                        pos_next = pos_reg + 1'b1;
                    else st_next = ulb_pkg::ST_BCONV;
                end
            ulb_pkg::ST_BCONV:
                if (conv_done) st_next = ulb_pkg::ST_BREP;
            ulb_pkg::ST_BREP:
                if (free_out && emit_last) st_next = ulb_pkg::ST_CLEAR;
            ulb_pkg::ST_CLEAR:
                st_next = ulb_pkg::ST_IDLE;
            default: st_next = ulb_pkg::ST_IDLE;
        endcase
    end

    assign job_take   = st_reg == ulb_pkg::ST_IDLE && job_valid;
    assign clear_line = st_reg == ulb_pkg::ST_CLEAR;
    // The line buffer is held still while a line or overflow job is pending.
    assign line_free  = st_reg == ulb_pkg::ST_IDLE || st_reg == ulb_pkg::ST_TICK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ulb_pkg::ST_IDLE;
            period_reg <= ulb_pkg::PERIOD_RESET;
            tick_reg   <= '0;
            bit_reg    <= '0;
            out_valid  <= 1'b0;
            for (int i = 0; i < LED_NUM; i++) pat_reg[i] <= ulb_pkg::PATTERN_RESET;
        end else begin
            st_reg <= st_next;
            out_valid <= out_set || (out_valid && !out_ready);
            if (st_reg == ulb_pkg::ST_TICK) begin
                if (tick_inc < period_reg) begin
                    tick_reg <= tick_inc;
                end else if (free_out) begin
                    tick_reg <= '0;
                    bit_reg  <= bit_reg + 4'd1;
                end
            end
            if (st_reg == ulb_pkg::ST_ZSET && rd_ok_reg &&
                cur_char >= ulb_pkg::CHAR_0 && cur_char <= ulb_pkg::CHAR_5)
                pat_reg[LI'(pos_reg - (LW+1)'(2))] <= ulb_pkg::code_mask(3'(cur_char - ulb_pkg::CHAR_0));
            // The first conversion cycle still holds the clamped period.
            if (st_reg == ulb_pkg::ST_BCONV && step_reg == 5'd0)
                period_reg <= val_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        rd_ok_reg <= (pos_next == pos_reg) && (st_reg != ulb_pkg::ST_IDLE);
        if (tick_fire) begin
            out_led <= 1'b1; out_levels <= lv; out_tx <= 1'b0; out_byte <= 8'h00;
            out_last <= 1'b1;
        end
        if (emit && free_out) begin
            out_led <= 1'b0; out_levels <= 8'h00; out_tx <= 1'b1; out_byte <= emit_byte;
            out_last <= emit_last;
        end
        if (st_reg == ulb_pkg::ST_IDLE || st_reg == ulb_pkg::ST_ZSET) begin
            step_reg <= '0;
        end else if (st_reg == ulb_pkg::ST_BDIG && st_next == ulb_pkg::ST_BCONV) begin
            step_reg <= '0;
        end else if (st_reg == ulb_pkg::ST_BCONV) begin
            step_reg <= conv_done ? 5'd0 : 5'd1;
        end else if (emit && free_out) begin
            // The digit step repeats until every digit has gone out.
            if (st_reg == ulb_pkg::ST_BREP && step_reg == 5'd2 && nd_reg > 3'd1)
                step_reg <= 5'd2;
            else
                step_reg <= step_reg + 5'd1;
        end
        if (st_reg == ulb_pkg::ST_BSKIP) begin
            val_reg <= '0; nd_reg <= '0;
        end
        if (st_reg == ulb_pkg::ST_BDIG && rd_ok_reg && st_next == ulb_pkg::ST_BDIG) begin
            if (({val_reg, 3'b0} + {2'b0, val_reg, 1'b0} + 20'(cur_char - ulb_pkg::CHAR_0))
                > 20'd65535)
                val_reg <= 17'd65535;
            else
                val_reg <= 17'(({val_reg, 3'b0} + {2'b0, val_reg, 1'b0})
                               + 20'(cur_char - ulb_pkg::CHAR_0));
        end
        if (st_reg == ulb_pkg::ST_BDIG && st_next == ulb_pkg::ST_BCONV) begin
            if (val_reg < {1'b0, min_period}) val_reg <= {1'b0, min_period};
        end
        if (st_reg == ulb_pkg::ST_BCONV && !conv_done) begin
            dig_reg[nd_reg] <= ulb_pkg::CHAR_0 + {4'b0, div_r};
            val_reg <= {4'b0, div_q};
            nd_reg  <= nd_reg + 3'd1;
        end
        if (st_reg == ulb_pkg::ST_BREP && emit && free_out) begin
            if (step_reg == 5'd2 && nd_reg > 3'd1)
                nd_reg <= nd_reg - 3'd1;
        end
    end
endmodule
`default_nettype wire

@@ sim/tb_uart_led_blink_command_controller_core.sv @@
`timescale 1ns / 1ps
module tb_uart_led_blink_command_controller_core;

    typedef struct {
        bit         led_upd;
        logic [7:0] levels;
        bit         tx_v;
        logic [7:0] tx_ch;
        bit         fin;
    } reply_t;

    typedef struct {
        bit    tick;
        int    count;
        string txt;
        string typed;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // rx_byte
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // led_update, led_levels, tx_valid, tx_byte, pad
    logic        m_tlast;   // last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;  // min_period_ms

    uart_led_blink_command_controller_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [7:0]  line_mem [32];
    int          line_len;
    logic [15:0] patterns [8];
    logic [15:0] period;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_pos;
    logic [15:0] min_period;

    reply_t pending_q[$];
    reply_t step_q[$];
    int     err_cnt = 0;
    int     beats_sent = 0;
    int     beats_seen = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     hold_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic logic [7:0] line_at(input int pos);
        return (pos < line_len && pos < 32) ? line_mem[pos] : 8'h00;
    endfunction

    function automatic logic [15:0] mask_of(input logic [7:0] c);
        case (c - ulb_pkg::CHAR_0)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hFF00;
            3: return 16'hF0F0;
            4: return 16'hCCCC;
            default: return 16'hAAAA;
        endcase
    endfunction

    function automatic logic [7:0] code_of(input logic [15:0] p);
        for (int k = 0; k < 6; k++)
            if (mask_of(ulb_pkg::CHAR_0 + k) == p) return ulb_pkg::CHAR_0 + k;
        return ulb_pkg::CHAR_E;
    endfunction

    task automatic add_char(input logic [7:0] c);
        reply_t r;
        r = '{led_upd: 0, levels: 8'h00, tx_v: 1, tx_ch: c, fin: 0};
        step_q.push_back(r);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic pattern_reply();
        add_text("z ");
        for (int i = 0; i < 8; i++) add_char(code_of(patterns[i]));
        add_char(ulb_pkg::CHAR_CR);
        add_char(ulb_pkg::CHAR_LF);
    endtask

    task automatic period_reply();
        int          pos;
        int          val;
        logic [7:0]  c;
        pos = 2;
        val = 0;
        c = line_at(pos);
        while (pos < 32 && (c == ulb_pkg::CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D))) begin
            pos++;
            c = line_at(pos);
        end
        while (pos < 32 && c >= ulb_pkg::CHAR_0 && c <= ulb_pkg::CHAR_9) begin
            val = val * 10 + (c - ulb_pkg::CHAR_0);
            if (val > 65535) val = 65535;
            pos++;
            c = line_at(pos);
        end
        if (val < min_period) val = min_period;
        period = val[15:0];
        add_text($sformatf("b %0d", val));
        add_char(ulb_pkg::CHAR_CR);
        add_char(ulb_pkg::CHAR_LF);
    endtask

    task automatic clear_line();
        for (int i = 0; i < 32; i++) line_mem[i] = 8'h00;
        line_len = 0;
    endtask

    // Works out the beats that one input beat causes, into step_q.
    task automatic predict_replies(input bit op, input logic [7:0] b);
        reply_t r;
        logic [7:0] lv;
        step_q.delete();
        if (op) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= period) begin
                tick_cnt = 0;
                for (int i = 0; i < 8; i++) lv[i] = patterns[i][bit_pos];
                bit_pos = bit_pos + 4'd1;
                r = '{led_upd: 1, levels: lv, tx_v: 0, tx_ch: 8'h00, fin: 1};
                step_q.push_back(r);
            end
        end else if (line_len >= 32) begin
            add_text("Command too long, ignoring");
            clear_line();
        end else if (b == ulb_pkg::CHAR_CR) begin
            if (line_at(0) == ulb_pkg::CHAR_Z) begin
                for (int i = 0; i < 8; i++)
                    if (line_at(2 + i) >= ulb_pkg::CHAR_0 && line_at(2 + i) <= ulb_pkg::CHAR_5)
                        patterns[i] = mask_of(line_at(2 + i));
                pattern_reply();
            end else if (line_at(0) == ulb_pkg::CHAR_S) begin
                pattern_reply();
            end else if (line_at(0) == ulb_pkg::CHAR_B) begin
                period_reply();
            end
            clear_line();
        end else begin
            line_mem[line_len] = b;
            line_len++;
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].fin = 1;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input bit op, input logic [7:0] b, input string typed);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        predict_replies(op, b);
        if (typed.len() > 0) begin
            step_q.delete();
            add_text(typed);
            step_q[step_q.size() - 1].fin = 1;
        end
        foreach (step_q[i]) pending_q.push_back(step_q[i]);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i], "");
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() > 0) @(negedge aclk);
        // A line that causes no reply may still be in work.
        repeat (120) @(negedge aclk);
    endtask

    task automatic write_min_period(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        min_period = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_command();
        string s;
        int    n;
        case ($urandom_range(9))
            0, 1: begin
                s = {"Z", string'(8'($urandom_range(32, 126)))};
                n = $urandom_range(0, 9);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h2F, 8'h37)))};
                send_line({s, "\r"});
            end
            2: send_line("S\r");
            3, 4: begin
                s = "B ";
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    s = {s, ($urandom_range(1) ? " " : string'(8'($urandom_range(9, 12))))};
                n = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 1);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h30, 8'h39)))};
                if ($urandom_range(3) == 0) s = {s, "-x"};
                send_line({s, "\r"});
            end
            5: begin
                s = {string'(8'($urandom_range(8'h61, 8'h7E))), "12"};
                send_line({s, "\r"});
            end
            6: begin
                n = $urandom_range(32, 36);
                for (int i = 0; i < n; i++) send_beat(1'b0, 8'($urandom_range(8'h20, 8'hFF)), "");
                send_line("\r");
            end
            7: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) send_beat(1'b0, 8'($urandom_range(255)), "");
            end
            default: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) send_beat(1'b1, 8'($urandom_range(255)), "");
            end
        endcase
    endtask

    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        reply_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", m_tdata));
            end else begin
                e = pending_q.pop_front();
                if (m_tdata[0] !== e.led_upd)
                    report_mismatch($sformatf("led_update %b, want %b", m_tdata[0], e.led_upd));
                if (m_tdata[8:1] !== e.levels)
                    report_mismatch($sformatf("led_levels %h, want %h", m_tdata[8:1], e.levels));
                if (m_tdata[9] !== e.tx_v)
                    report_mismatch($sformatf("tx_valid %b, want %b", m_tdata[9], e.tx_v));
                if (m_tdata[17:10] !== e.tx_ch)
                    report_mismatch($sformatf("tx_byte %h, want %h", m_tdata[17:10], e.tx_ch));
                if (m_tlast !== e.fin)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, e.fin));
            end
        end
    end

    initial begin
        #20ms;
        $display("Timeout with %0d beats outstanding", pending_q.size());
        $display("Test completed with failures");
        $finish;
    end

    row_t rows[$];
    int   limit;

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = 8'h00;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 16'h0000;
        clear_line();
        for (int i = 0; i < 8; i++) patterns[i] = ulb_pkg::PATTERN_RESET;
        period     = ulb_pkg::PERIOD_RESET;
        tick_cnt   = 0;
        bit_pos    = 0;
        min_period = ulb_pkg::MIN_PERIOD_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        rows = '{
            '{0, 0, "S\r",          "z 22222222\r\n"},
            '{0, 0, "Z 012345X9\r", "z 01234522\r\n"},
            '{0, 0, "Z\r",          "z 01234522\r\n"},
            '{0, 0, "B 0\r",        "b 1\r\n"},
            '{0, 0, "B 99999\r",    "b 65535\r\n"},
            '{0, 0, "B \t 2\r",     ""},
            '{1, 6, "",             ""},
            '{0, 0, "Z x5432\r",    ""},
            '{1, 9, "",             ""},
            '{0, 0, "B 1\r",        ""},
            '{1, 4, "",             ""},
            '{0, 0, "Q\r",          ""},
            '{0, 0, "\r",           ""},
            '{0, 0, "B -7\r",       ""},
            '{0, 0, "S\r",          ""}
        };
        write_min_period(16'd1);
        foreach (rows[i]) begin
            if (rows[i].tick) begin
                for (int k = 0; k < rows[i].count; k++) send_beat(1'b1, 8'hFF, "");
            end else begin
                for (int k = 0; k < rows[i].txt.len(); k++)
                    send_beat(1'b0, rows[i].txt[k],
                              (k == rows[i].txt.len() - 1) ? rows[i].typed : "");
            end
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_min_period(16'd65535); end
                1: begin
                    idle_pct = 71; stall_pct = 0;
                    write_min_period(ulb_pkg::MIN_PERIOD_RESET);
                end
                2: begin idle_pct = 0;  stall_pct = 71; write_min_period(16'd1); end
                default: begin
                    idle_pct = 32; stall_pct = 32;
                    write_min_period(16'($urandom_range(1, 6)));
                end
            endcase
            send_line("B 3\r");
            if (ph == 2) begin
                // Long receiver hold while the sender keeps offering beats.
                s_tvalid <= 1'b0;
                @(posedge aclk);
                hold_cnt = 400;
                @(negedge aclk);
            end
            limit = beats_sent + 36;
            while (beats_sent < limit) random_command();
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;

        $display("Covered %0d input beats and %0d result beats over four handshake phases,",
                 beats_sent, beats_seen);
        $display("with pattern, status, period, overflow and tick traffic.");
        if (pending_q.size() > 0)
            report_mismatch($sformatf("%0d beats never arrived", pending_q.size()));
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
